@@ design/assert_macros.svh @@
// Assertion macros shared by the line clipper RTL.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define LSC_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define LSC_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition");
`else
`define LSC_ASSERT(lbl, clk, rst_n, prop)
`define LSC_NEVER(lbl, clk, rst_n, cond)
`endif
`endif

@@ design/lsc_pkg.sv @@
// Types and constants for the line segment window clipper.
// No dependencies.
package lsc_pkg;
    localparam int COORD_BITS = 16;
    localparam int LANES      = 4;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_TOP    = 2'd2;
    localparam logic [1:0] CFG_BOTTOM = 2'd3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] start_x;
        logic signed [COORD_BITS-1:0] start_y;
        logic signed [COORD_BITS-1:0] end_x;
        logic signed [COORD_BITS-1:0] end_y;
    } t_seg_in;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] clipped_start_x;
        logic signed [COORD_BITS-1:0] clipped_start_y;
        logic signed [COORD_BITS-1:0] clipped_end_x;
        logic signed [COORD_BITS-1:0] clipped_end_y;
        logic                         visible;
    } t_seg_out;

    typedef struct packed {
        logic [COORD_BITS-1:0] x0;
        logic [COORD_BITS-1:0] y0;
        logic [COORD_BITS:0]   dx;
        logic [COORD_BITS:0]   dy;
        logic                  rej;
    } t_geo;

    typedef struct packed {
        logic [COORD_BITS-1:0] rem;
        logic [COORD_BITS-1:0] den;
        logic                  sat;
        logic                  act;
    } t_lane;
endpackage

@@ design/line_segment_window_clipper_core.sv @@
// Throughput: one segment per cycle while i_stall is low; a chain of FRAC_BITS
// divider cells forms one quotient bit per cell, followed by reduce, multiply
// and add stages. Reset (synchronous, active low) empties the pipeline and loads
// the window to left 0, right 639, top 0, bottom 479.
module line_segment_window_clipper_core import lsc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  logic                  i_valid,
    input  t_seg_in               i_seg,
    output logic                  o_stall,
    output logic                  o_valid,
    output t_seg_out              o_seg,
    input  logic                  i_stall
);
    logic                            w_v    [FRAC_BITS+1];
    logic                            w_rdy  [FRAC_BITS+1];
    t_geo                            w_geo  [FRAC_BITS+1];
    t_lane [LANES-1:0]               w_lane [FRAC_BITS+1];
    logic [LANES-1:0][FRAC_BITS-1:0] w_quot [FRAC_BITS+1];
    logic                            front_rdy;

    assign o_stall   = !front_rdy;
    assign w_quot[0] = '0;

    lsc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_v        (i_valid),
        .i_seg      (i_seg),
        .o_rdy      (front_rdy),
        .o_v        (w_v[0]),
        .o_geo      (w_geo[0]),
        .o_lane     (w_lane[0]),
        .i_rdy      (w_rdy[0])
    );

    for (genvar k = 0; k < FRAC_BITS; k++) begin : g_cell
        lsc_div_cell #(.FRAC_BITS(FRAC_BITS)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_v     (w_v[k]),
            .i_geo   (w_geo[k]),
            .i_lane  (w_lane[k]),
            .i_quot  (w_quot[k]),
            .o_rdy   (w_rdy[k]),
            .o_v     (w_v[k+1]),
            .o_geo   (w_geo[k+1]),
            .o_lane  (w_lane[k+1]),
            .o_quot  (w_quot[k+1]),
            .i_rdy   (w_rdy[k+1])
        );
    end

    lsc_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_v     (w_v[FRAC_BITS]),
        .i_geo   (w_geo[FRAC_BITS]),
        .i_lane  (w_lane[FRAC_BITS]),
        .i_quot  (w_quot[FRAC_BITS]),
        .o_rdy   (w_rdy[FRAC_BITS]),
        .o_valid (o_valid),
        .o_seg   (o_seg),
        .i_stall (i_stall)
    );
endmodule

@@ design/lsc_front.sv @@
// Front cell: window registers, boundary terms p/q and divider setup.
// Depends on lsc_pkg.
module lsc_front import lsc_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [1:0]            i_cfg_idx,
    input  logic [COORD_BITS-1:0] i_cfg_data,
    input  logic                  i_v,
    input  t_seg_in               i_seg,
    output logic                  o_rdy,
    output logic                  o_v,
    output t_geo                  o_geo,
    output t_lane [LANES-1:0]     o_lane,
    input  logic                  i_rdy
);
    logic [COORD_BITS-1:0] r_left, r_right, r_top, r_bottom;
    logic                  r_v;
    t_geo                  r_geo, n_geo;
    t_lane [LANES-1:0]     r_lane, n_lane;
    logic                  take;
    logic [COORD_BITS:0]   p [LANES];
    logic [COORD_BITS:0]   q [LANES];
    logic [COORD_BITS:0]   ap, aq, sx, sy;
    logic                  pz, pn, qn, rej;
    logic                  sw;
    logic [1:0]            j;

    assign take  = !r_v || i_rdy;
    assign o_rdy = take;
    assign o_v   = r_v;
    assign o_geo = r_geo;
    assign o_lane = r_lane;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left   <= COORD_BITS'(0);
            r_right  <= COORD_BITS'(639);
            r_top    <= COORD_BITS'(0);
            r_bottom <= COORD_BITS'(479);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_RIGHT:  r_right  <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data;
                CFG_BOTTOM: r_bottom <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // even lanes carry the entry edge of an axis, odd lanes the exit edge
    always_comb begin
        sx = {i_seg.start_x[COORD_BITS-1], i_seg.start_x};
        sy = {i_seg.start_y[COORD_BITS-1], i_seg.start_y};
        n_geo.x0 = i_seg.start_x;
        n_geo.y0 = i_seg.start_y;
        n_geo.dx = {i_seg.end_x[COORD_BITS-1], i_seg.end_x} - sx;
        n_geo.dy = {i_seg.end_y[COORD_BITS-1], i_seg.end_y} - sy;
        p[0] = -n_geo.dx;
        p[1] = n_geo.dx;
        p[2] = -n_geo.dy;
        p[3] = n_geo.dy;
        q[0] = sx - {r_left[COORD_BITS-1], r_left};
        q[1] = {r_right[COORD_BITS-1], r_right} - sx;
        q[2] = sy - {r_top[COORD_BITS-1], r_top};
        q[3] = {r_bottom[COORD_BITS-1], r_bottom} - sy;
        rej = 1'b0;
        n_lane = '0;
        for (int i = 0; i < LANES; i++) begin
            sw = (i < 2) ? n_geo.dx[COORD_BITS] : n_geo.dy[COORD_BITS];
            j  = 2'(i) ^ {1'b0, sw};
            pz = (p[i] == '0);
            pn = p[i][COORD_BITS];
            qn = q[i][COORD_BITS];
            ap = pn ? -p[i] : p[i];
            aq = qn ? -q[i] : q[i];
            rej = rej || (qn && !pn);
            n_lane[j].rem = aq[COORD_BITS-1:0];
            n_lane[j].den = ap[COORD_BITS-1:0];
            n_lane[j].sat = aq[COORD_BITS-1:0] >= ap[COORD_BITS-1:0];
            n_lane[j].act = j[0] ? (!pn && !pz) : (pn && qn);
        end
        n_geo.rej = rej;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_v) begin
            r_geo  <= n_geo;
            r_lane <= n_lane;
        end
    end
endmodule

@@ design/lsc_div_cell.sv @@
// Divider cell: one quotient bit of each boundary ratio per stage.
// Depends on lsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lsc_div_cell import lsc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_v,
    input  t_geo                             i_geo,
    input  t_lane [LANES-1:0]                i_lane,
    input  logic [LANES-1:0][FRAC_BITS-1:0]  i_quot,
    output logic                             o_rdy,
    output logic                             o_v,
    output t_geo                             o_geo,
    output t_lane [LANES-1:0]                o_lane,
    output logic [LANES-1:0][FRAC_BITS-1:0]  o_quot,
    input  logic                             i_rdy
);
    logic                            r_v, take;
    t_geo                            r_geo;
    t_lane [LANES-1:0]               r_lane, n_lane;
    logic [LANES-1:0][FRAC_BITS-1:0] r_quot, n_quot;
    logic [COORD_BITS:0]             r2, diff;
    logic                            ge;

    assign take   = !r_v || i_rdy;
    assign o_rdy  = take;
    assign o_v    = r_v;
    assign o_geo  = r_geo;
    assign o_lane = r_lane;
    assign o_quot = r_quot;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            r2   = {i_lane[i].rem, 1'b0};
            diff = r2 - {1'b0, i_lane[i].den};
            ge   = r2 >= {1'b0, i_lane[i].den};
            n_lane[i]     = i_lane[i];
            n_lane[i].rem = ge ? diff[COORD_BITS-1:0] : r2[COORD_BITS-1:0];
            n_quot[i]     = {i_quot[i][FRAC_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= i_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && i_v) begin
            r_geo  <= i_geo;
            r_lane <= n_lane;
            r_quot <= n_quot;
        end
    end

    `LSC_NEVER(a_rem_below_den, i_clk, i_rst_n, r_v && r_lane[0].act && !r_lane[0].sat && (r_lane[0].rem >= r_lane[0].den))
endmodule

@@ design/lsc_back.sv @@
// Back end: entry/exit reduction, endpoint products, final adds.
// Depends on lsc_pkg and assert_macros.svh.
`include "assert_macros.svh"
module lsc_back import lsc_pkg::*; #(
    parameter int FRAC_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_v,
    input  t_geo                             i_geo,
    input  t_lane [LANES-1:0]                i_lane,
    input  logic [LANES-1:0][FRAC_BITS-1:0]  i_quot,
    output logic                             o_rdy,
    output logic                             o_valid,
    output t_seg_out                         o_seg,
    input  logic                             i_stall
);
    localparam int TW = FRAC_BITS + 1;
    localparam int PW = COORD_BITS + TW;
    localparam logic [TW-1:0] T_ONE = {1'b1, {FRAC_BITS{1'b0}}};

    logic              r_a_v, r_b_v, r_c_v, take_a, take_b, take_c;
    t_geo              r_a_geo, r_b_geo;
    logic [TW-1:0]     r_a_t0, r_a_t1, n_t0, n_t1;
    logic [TW-1:0]     t [LANES];
    logic              r_a_vis, r_b_vis;
    logic [PW-1:0]     r_b_p [4];
    logic [COORD_BITS-1:0] mdx, mdy;
    t_seg_out          r_c_seg, n_seg;
    logic [COORD_BITS-1:0] off [4];
    logic [COORD_BITS-1:0] sgn [4];

    assign take_c  = !r_c_v || !i_stall;
    assign take_b  = !r_b_v || take_c;
    assign take_a  = !r_a_v || take_b;
    assign o_rdy   = take_a;
    assign o_valid = r_c_v;
    assign o_seg   = r_c_seg;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            t[i] = i_lane[i].sat ? T_ONE : {1'b0, i_quot[i]};
        end
        n_t0 = '0;
        n_t1 = T_ONE;
        for (int i = 0; i < LANES; i += 2) begin
            if (i_lane[i].act && t[i] > n_t0) begin
                n_t0 = t[i];
            end
            if (i_lane[i+1].act && t[i+1] < n_t1) begin
                n_t1 = t[i+1];
            end
        end
    end

    always_comb begin
        mdx = r_a_geo.dx[COORD_BITS] ? COORD_BITS'(-r_a_geo.dx) : r_a_geo.dx[COORD_BITS-1:0];
        mdy = r_a_geo.dy[COORD_BITS] ? COORD_BITS'(-r_a_geo.dy) : r_a_geo.dy[COORD_BITS-1:0];
    end

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            off[i] = r_b_p[i][FRAC_BITS +: COORD_BITS];
        end
        sgn[0] = r_b_geo.dx[COORD_BITS] ? -off[0] : off[0];
        sgn[1] = r_b_geo.dy[COORD_BITS] ? -off[1] : off[1];
        sgn[2] = r_b_geo.dx[COORD_BITS] ? -off[2] : off[2];
        sgn[3] = r_b_geo.dy[COORD_BITS] ? -off[3] : off[3];
        if (r_b_vis) begin
            n_seg.clipped_start_x = r_b_geo.x0 + sgn[0];
            n_seg.clipped_start_y = r_b_geo.y0 + sgn[1];
            n_seg.clipped_end_x   = r_b_geo.x0 + sgn[2];
            n_seg.clipped_end_y   = r_b_geo.y0 + sgn[3];
        end else begin
            n_seg.clipped_start_x = r_b_geo.x0;
            n_seg.clipped_start_y = r_b_geo.y0;
            n_seg.clipped_end_x   = r_b_geo.x0 + r_b_geo.dx[COORD_BITS-1:0];
            n_seg.clipped_end_y   = r_b_geo.y0 + r_b_geo.dy[COORD_BITS-1:0];
        end
        n_seg.visible = r_b_vis;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_v <= 1'b0;
            r_b_v <= 1'b0;
            r_c_v <= 1'b0;
        end else begin
            if (take_a) begin
                r_a_v <= i_v;
            end
            if (take_b) begin
                r_b_v <= r_a_v;
            end
            if (take_c) begin
                r_c_v <= r_b_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take_a && i_v) begin
            r_a_geo <= i_geo;
            r_a_t0  <= n_t0;
            r_a_t1  <= n_t1;
            r_a_vis <= !i_geo.rej && (n_t0 < n_t1);
        end
        if (take_b && r_a_v) begin
            r_b_geo  <= r_a_geo;
            r_b_vis  <= r_a_vis;
            r_b_p[0] <= PW'(mdx) * PW'(r_a_t0);
            r_b_p[1] <= PW'(mdy) * PW'(r_a_t0);
            r_b_p[2] <= PW'(mdx) * PW'(r_a_t1);
            r_b_p[3] <= PW'(mdy) * PW'(r_a_t1);
        end
        if (take_c && r_b_v) begin
            r_c_seg <= n_seg;
        end
    end

    `LSC_NEVER(a_t1_le_one, i_clk, i_rst_n, r_a_v && (r_a_t1 > T_ONE))
    `LSC_NEVER(a_t0_le_one, i_clk, i_rst_n, r_a_v && (r_a_t0 > T_ONE))
endmodule

@@ tb/line_segment_window_clipper_core_tb.sv @@
// Testbench for line_segment_window_clipper_core: random and directed segments
// checked against a behavioral Liang-Barsky clipper. Depends on lsc_pkg and the core.
module line_segment_window_clipper_core_tb;
    import lsc_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = 16;
    localparam int LATENCY = FRAC + 4;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [1:0] i_cfg_idx = CFG_LEFT;
    logic [COORD_BITS-1:0] i_cfg_data = '0;
    logic i_valid = 1'b0;
    t_seg_in i_seg = '0;
    logic o_stall;
    logic o_valid;
    t_seg_out o_seg;
    logic i_stall = 1'b0;

    line_segment_window_clipper_core #(.FRAC_BITS(FRAC)) i_dut (.*);

    always #4 i_clk = ~i_clk;

    logic signed [COORD_BITS-1:0] win_l = 0, win_r = 639, win_t = 0, win_b = 479;
    t_seg_in pending_segs[$];
    t_seg_out expected_clips[$];
    int errors = 0;
    bit calm = 1'b0;
    bit hold_sender = 1'b0;
    int long_hold = 0;
    int src_gap = 0;
    int snk_gap = 0;
    logic took_q = 1'b0;

    function automatic longint scale_ofs(longint d, longint t);
        longint m;
        m = (d < 0) ? -d : d;
        m = (m * t) >>> FRAC;
        return (d < 0) ? -m : m;
    endfunction

    function automatic t_seg_out clip_segment(t_seg_in s);
        longint x0, y0, dx, dy, t0, t1, r;
        longint p[4];
        longint q[4];
        bit ok;
        t_seg_out o;
        x0 = s.start_x; y0 = s.start_y;
        dx = longint'(s.end_x) - x0; dy = longint'(s.end_y) - y0;
        p[0] = -dx; q[0] = x0 - win_l;
        p[1] = dx;  q[1] = win_r - x0;
        p[2] = -dy; q[2] = y0 - win_t;
        p[3] = dy;  q[3] = win_b - y0;
        t0 = 0; t1 = 1 << FRAC; ok = 1'b1;
        for (int i = 0; i < 4; i++) begin
            if (p[i] == 0) begin
                if (q[i] < 0) ok = 1'b0;
            end else if (p[i] < 0) begin
                if (q[i] < 0) begin
                    r = ((-q[i]) << FRAC) / (-p[i]);
                    if (r > t0) t0 = r;
                end
            end else if (q[i] < 0) begin
                ok = 1'b0;
            end else begin
                r = (q[i] << FRAC) / p[i];
                if (r < t1) t1 = r;
            end
        end
        if (ok && t0 < t1) begin
            o.clipped_start_x = COORD_BITS'(x0 + scale_ofs(dx, t0));
            o.clipped_start_y = COORD_BITS'(y0 + scale_ofs(dy, t0));
            o.clipped_end_x = COORD_BITS'(x0 + scale_ofs(dx, t1));
            o.clipped_end_y = COORD_BITS'(y0 + scale_ofs(dy, t1));
            o.visible = 1'b1;
        end else begin
            o.clipped_start_x = s.start_x;
            o.clipped_start_y = s.start_y;
            o.clipped_end_x = s.end_x;
            o.clipped_end_y = s.end_y;
            o.visible = 1'b0;
        end
        return o;
    endfunction

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || took_q) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    i_valid <= 1'b0;
                end else if (pending_segs.size() > 0 && !hold_sender) begin
                    if (!calm && $urandom_range(0, 15) == 0) begin
                        src_gap <= $urandom_range(1, 14);
                        i_valid <= 1'b0;
                    end else begin
                        i_seg <= pending_segs.pop_front();
                        i_valid <= 1'b1;
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (long_hold > 0) begin
                long_hold <= long_hold - 1;
                i_stall <= 1'b1;
            end else if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                i_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                snk_gap <= $urandom_range(1, 14);
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_seg_out want;
        took_q <= i_rst_n && i_valid && !o_stall;
        if (i_rst_n && i_valid && !o_stall) expected_clips.push_back(clip_segment(i_seg));
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_clips.size() == 0) begin
                $error("result with nothing expected");
                errors++;
            end else begin
                want = expected_clips.pop_front();
                if (o_seg.clipped_start_x !== want.clipped_start_x) begin
                    $error("clipped_start_x exp %0d got %0d", want.clipped_start_x,
                           o_seg.clipped_start_x);
                    errors++;
                end
                if (o_seg.clipped_start_y !== want.clipped_start_y) begin
                    $error("clipped_start_y exp %0d got %0d", want.clipped_start_y,
                           o_seg.clipped_start_y);
                    errors++;
                end
                if (o_seg.clipped_end_x !== want.clipped_end_x) begin
                    $error("clipped_end_x exp %0d got %0d", want.clipped_end_x,
                           o_seg.clipped_end_x);
                    errors++;
                end
                if (o_seg.clipped_end_y !== want.clipped_end_y) begin
                    $error("clipped_end_y exp %0d got %0d", want.clipped_end_y,
                           o_seg.clipped_end_y);
                    errors++;
                end
                if (o_seg.visible !== want.visible) begin
                    $error("visible exp %0d got %0d", want.visible, o_seg.visible);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        while (pending_segs.size() > 0 || i_valid || expected_clips.size() > 0)
            @(posedge i_clk);
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_window(logic signed [15:0] l, r, t, b);
        logic [1:0] idx[4];
        logic [15:0] val[4];
        idx = '{CFG_LEFT, CFG_RIGHT, CFG_TOP, CFG_BOTTOM};
        val = '{l, r, t, b};
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx[i];
            i_cfg_data <= val[i];
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        win_l = l; win_r = r; win_t = t; win_b = b;
    endtask

    function automatic logic [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 900) - 150);
            default: return 16'($urandom_range(0, 1) ? 16'h8000 + $urandom_range(0, 3)
                                                      : 16'h7fff - $urandom_range(0, 3));
        endcase
    endfunction

    task automatic add_random(int n, int mode_hi);
        t_seg_in s;
        for (int k = 0; k < n; k++) begin
            s.start_x = rand_coord($urandom_range(0, mode_hi));
            s.start_y = rand_coord($urandom_range(0, mode_hi));
            s.end_x = $urandom_range(0, 7) == 0 ? s.start_x : rand_coord($urandom_range(0, mode_hi));
            s.end_y = $urandom_range(0, 7) == 0 ? s.start_y : rand_coord($urandom_range(0, mode_hi));
            pending_segs.push_back(s);
        end
    endtask

    task automatic add_seg(int a, b, c, d);
        pending_segs.push_back('{16'(a), 16'(b), 16'(c), 16'(d)});
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // directed, reset window
        add_seg(-100, 240, 800, 240);
        add_seg(320, -50, 320, 600);
        add_seg(700, 100, 700, 300);
        add_seg(100, 100, 200, 200);
        add_seg(-10, -10, -10, -10);
        add_seg(50, 50, 50, 50);
        add_seg(0, 0, 639, 479);
        add_seg(639, 0, 700, -10);
        add_seg(-20, 500, 700, -40);
        add_seg(800, 240, -100, 240);
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, -32768, -32768, 32767);
        add_seg(-5, 0, 0, -5);
        add_seg(100, -5, 100, -1);
        drain();
        write_window(-32768, 32767, -32768, 32767);
        add_seg(-32768, -32768, 32767, 32767);
        add_seg(32767, 0, -32768, 0);
        add_random(200, 2);
        drain();
        write_window(10, 5, 0, 100);
        add_seg(0, 50, 20, 50);
        add_random(60, 1);
        drain();
        write_window(-200, 300, -100, 250);
        add_random(350, 1);
        add_random(150, 0);
        // long receiver hold while the sender keeps offering
        long_hold = 200;
        wait (long_hold == 0);
        hold_sender = 1'b1;
        wait (expected_clips.size() == 0);
        hold_sender = 1'b0;
        drain();
        write_window(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        add_random(250, 2);
        drain();
        write_window(0, 639, 0, 479);
        calm = 1'b1;
        add_random(200, 1);
        drain();
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #2ms;
        $display("CHECK FAILED");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+design
design/lsc_pkg.sv
design/lsc_front.sv
design/lsc_div_cell.sv
design/lsc_back.sv
design/line_segment_window_clipper_core.sv
tb/line_segment_window_clipper_core_tb.sv
